>>> rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int unsigned PoolBytesDef   = 4096;
  localparam int unsigned PoolResetBytes = 4096;
  localparam int unsigned MinPoolBytes   = 16;

  localparam int KindW = 1;
  localparam int ReqW  = 13;
  localparam int OffW  = 12;
  localparam int StatW = 2;
  localparam int CfgW  = 13;

  localparam int HdrBytes    = 4;
  localparam int FitSlack    = 8;
  localparam int SplitSlack  = 16;

  localparam logic [KindW-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KindW-1:0] KIND_FREE  = 1'b1;

  typedef enum logic [StatW-1:0] {
    ST_ALLOC_OK,
    ST_ALLOC_FAIL,
    ST_FREED,
    ST_DOUBLE_FREE
  } status_e;

endpackage

>>> rtl/ffba_ram.sv
module ffba_ram #(
  parameter int W     = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ffba_unit.sv
module ffba_unit #(
  parameter int W = 16
) (
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic signed [W-1:0] c_i,
  output logic signed [W-1:0] sum_o,
  output logic                ge_o
);

  // shared add and compare: sum = a + b, ge = (sum >= c)
  assign sum_o = a_i + b_i;
  assign ge_o  = (sum_o >= c_i);

endmodule

>>> rtl/first_fit_block_allocator.sv
// channel   direction  handshake               word
// config    in         cfg_we_i                cfg_wdata_i (pool size)
// request   in         start && !busy          kind_i, req_size_i, payload_offset_i
// result    out        done_o (one cycle)      alloc_offset_o, status_o
//
// busy states per word: free uses S_FREE_RD; allocate sends each skipped header
//   through S_FIT (read compare) and S_STEP (step add), the fitting one through
//   S_FIT, then writes the header(s) in S_SPLIT and, on a split, S_HALF.
// the walk rate is set by the single header memory read port and the shared adder.
// after reset the block is busy in S_INIT while header 0 is written.
// a result shows for one cycle as busy drops; the receiver cannot stall it.
module first_fit_block_allocator #(
  parameter int unsigned POOL_BYTES = ffba_pkg::PoolBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ffba_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      start,
  output logic                      busy,
  input  logic [ffba_pkg::KindW-1:0] kind_i,
  input  logic [ffba_pkg::ReqW-1:0] req_size_i,
  input  logic [ffba_pkg::OffW-1:0] payload_offset_i,
  output logic                      done_o,
  output logic [ffba_pkg::OffW-1:0] alloc_offset_o,
  output logic [ffba_pkg::StatW-1:0] status_o
);

  import ffba_pkg::*;

  localparam int AW = $clog2(POOL_BYTES);
  localparam int PW = $clog2(POOL_BYTES + 1);
  localparam int HW = AW + 2;
  localparam int CW = ((HW > ReqW + 1) ? HW : ReqW + 1) + 2;
  localparam logic [PW-1:0] PoolRst = (PoolResetBytes > POOL_BYTES) ?
                                      PW'(POOL_BYTES) : PW'(PoolResetBytes);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FIT,
    S_STEP,
    S_SPLIT,
    S_HALF,
    S_FREE_RD
  } state_e;

  function automatic logic [PW-1:0] clamp_pool(logic [CfgW-1:0] v);
    int x;
    x = int'(v);
    if (x < int'(MinPoolBytes)) x = int'(MinPoolBytes);
    if (x > int'(POOL_BYTES)) x = int'(POOL_BYTES);
    return PW'(x);
  endfunction

  state_e                state_q, state_d;
  logic [AW-1:0]         h_q, h_d;
  logic signed [CW-1:0]  need8_q, need8_d;
  logic signed [CW-1:0]  needsp_q, needsp_d;
  logic signed [HW-1:0]  s_q, s_d;
  logic                  bad_q, bad_d;
  logic [PW-1:0]         pool_q;
  logic                  done_q, done_d;
  logic [OffW-1:0]       offset_q, offset_d;
  status_e               status_q, status_d;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic signed [HW-1:0]  wdata, rdata;
  logic [HW-1:0]         mag;
  logic signed [HW-1:0]  half, rest;
  logic signed [CW-1:0]  ua, ub, uc, usum;
  logic                  uge;
  logic [OffW-1:0]       grant_off;

  ffba_ram #(
    .W     (HW),
    .DEPTH (POOL_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ffba_unit #(
    .W (CW)
  ) u_unit (
    .a_i   (ua),
    .b_i   (ub),
    .c_i   (uc),
    .sum_o (usum),
    .ge_o  (uge)
  );

  assign mag       = rdata[HW-1] ? HW'(-rdata) : HW'(rdata);
  assign half      = s_q >>> 1;
  assign rest      = s_q - half;
  assign grant_off = OffW'(int'(h_q) + HdrBytes);

  always_comb begin
    state_d  = state_q;
    h_d      = h_q;
    need8_d  = need8_q;
    needsp_d = needsp_q;
    s_d      = s_q;
    bad_d    = bad_q;
    done_d   = 1'b0;
    offset_d = offset_q;
    status_d = status_q;
    raddr    = h_q;
    we       = 1'b0;
    waddr    = h_q;
    wdata    = -s_q;
    ua       = CW'(rdata);
    ub       = '0;
    uc       = need8_q;

    if (cfg_we_i) begin
      we    = 1'b1;
      waddr = '0;
      wdata = HW'(clamp_pool(cfg_wdata_i));
    end

    case (state_q)
      S_INIT: begin
        if (!cfg_we_i) begin
          we    = 1'b1;
          waddr = '0;
          wdata = HW'(pool_q);
        end
        state_d = S_IDLE;
      end
      S_IDLE: begin
        // free check: header address = offset - 4, must be below pool size
        ua = CW'(payload_offset_i);
        ub = -CW'(HdrBytes);
        uc = CW'(pool_q);
        if (start) begin
          need8_d  = CW'(req_size_i) + CW'(FitSlack);
          needsp_d = (CW'(req_size_i) <<< 1) + CW'(SplitSlack + 1);
          if (kind_i == KIND_ALLOC) begin
            h_d     = '0;
            raddr   = '0;
            state_d = S_FIT;
          end else begin
            h_d     = usum[AW-1:0];
            raddr   = usum[AW-1:0];
            bad_d   = usum[CW-1] || uge;
            state_d = S_FREE_RD;
          end
        end
      end
      S_FIT: begin
        ua = CW'(rdata);
        ub = '0;
        uc = need8_q;
        if (uge) begin
          s_d     = rdata;
          state_d = S_SPLIT;
        end else if (mag == '0) begin
          done_d   = 1'b1;
          offset_d = '0;
          status_d = ST_ALLOC_FAIL;
          state_d  = S_IDLE;
        end else begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        ua = CW'(h_q);
        ub = CW'(mag);
        uc = CW'(pool_q);
        if (uge) begin
          done_d   = 1'b1;
          offset_d = '0;
          status_d = ST_ALLOC_FAIL;
          state_d  = S_IDLE;
        end else begin
          h_d     = usum[AW-1:0];
          raddr   = usum[AW-1:0];
          state_d = S_FIT;
        end
      end
      S_SPLIT: begin
        ua    = CW'(s_q);
        ub    = '0;
        uc    = needsp_q;
        we    = 1'b1;
        waddr = h_q;
        if (uge) begin
          wdata   = -half;
          state_d = S_HALF;
        end else begin
          wdata    = -s_q;
          done_d   = 1'b1;
          offset_d = grant_off;
          status_d = ST_ALLOC_OK;
          state_d  = S_IDLE;
        end
      end
      S_HALF: begin
        ua = CW'(h_q);
        ub = CW'(half);
        uc = CW'(POOL_BYTES);
        if (!uge) begin
          we    = 1'b1;
          waddr = usum[AW-1:0];
          wdata = rest;
        end
        done_d   = 1'b1;
        offset_d = grant_off;
        status_d = ST_ALLOC_OK;
        state_d  = S_IDLE;
      end
      S_FREE_RD: begin
        done_d   = 1'b1;
        offset_d = '0;
        status_d = ST_DOUBLE_FREE;
        if (!bad_q && rdata[HW-1]) begin
          we       = 1'b1;
          waddr    = h_q;
          wdata    = -rdata;
          status_d = ST_FREED;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      pool_q   <= PoolRst;
      h_q      <= '0;
      need8_q  <= '0;
      needsp_q <= '0;
      s_q      <= '0;
      bad_q    <= 1'b0;
      done_q   <= 1'b0;
      offset_q <= '0;
      status_q <= ST_ALLOC_OK;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        pool_q <= clamp_pool(cfg_wdata_i);
      end
      h_q      <= h_d;
      need8_q  <= need8_d;
      needsp_q <= needsp_d;
      s_q      <= s_d;
      bad_q    <= bad_d;
      done_q   <= done_d;
      offset_q <= offset_d;
      status_q <= status_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign alloc_offset_o = offset_q;
  assign status_o       = status_q;

endmodule

>>> rtl/ffba_checker.sv
module ffba_props (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [ffba_pkg::KindW-1:0] kind_i,
  input logic                      done_o,
  input logic [ffba_pkg::OffW-1:0] alloc_offset_o,
  input logic [ffba_pkg::StatW-1:0] status_o
);

  import ffba_pkg::*;

  // a result appears only as the block goes idle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result without a finished request");

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // free answers after its S_FREE_RD state with a freed or double-free status
  a_free_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == KIND_FREE) |-> ##2
      (done_o && (status_o == ST_FREED || status_o == ST_DOUBLE_FREE)))
    else $error("free result missing or wrong kind");

  // only a granted allocation carries an offset
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_ALLOC_OK) |-> (alloc_offset_o == '0))
    else $error("offset on a non-granted result");

endmodule

bind first_fit_block_allocator ffba_props u_ffba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .kind_i         (kind_i),
  .done_o         (done_o),
  .alloc_offset_o (alloc_offset_o),
  .status_o       (status_o)
);

>>> tb/ffba_checker.sv
`timescale 1ns / 1ps

module ffba_checker #(
  parameter int unsigned POOL_BYTES = ffba_pkg::PoolBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ffba_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [ffba_pkg::KindW-1:0] kind_i,
  input  logic [ffba_pkg::ReqW-1:0]  req_size_i,
  input  logic [ffba_pkg::OffW-1:0]  payload_offset_i,
  input  logic                       done_i,
  input  logic [ffba_pkg::OffW-1:0]  alloc_offset_i,
  input  logic [ffba_pkg::StatW-1:0] status_i,
  output int                         errors_o,
  output int                         pending_o
);

  import ffba_pkg::*;

  typedef struct packed {
    logic [OffW-1:0] offset;
    status_e         status;
  } grant_t;

  logic signed [13:0] hdr_mem [POOL_BYTES];
  int                 pool_bytes;
  int                 err_count;
  grant_t             grant_q [$];

  function automatic void form_pool(input logic [CfgW-1:0] value);
    int v;
    v = int'(value);
    if (v < int'(MinPoolBytes)) v = int'(MinPoolBytes);
    if (v > int'(POOL_BYTES)) v = int'(POOL_BYTES);
    pool_bytes = v;
    hdr_mem[0] = 14'(v);
  endfunction

  function automatic grant_t first_fit_alloc(input int need);
    int     h;
    int     s;
    int     step;
    int     half;
    bit     found;
    bit     walking;
    grant_t r;
    h = 0;
    found = 1'b0;
    walking = 1'b1;
    while (walking && h < pool_bytes) begin
      s = hdr_mem[h];
      if (s >= need + FitSlack) begin
        found = 1'b1;
        walking = 1'b0;
      end else begin
        step = (s < 0) ? -s : s;
        if (step == 0) walking = 1'b0;
        else if (step >= pool_bytes - h) h = pool_bytes;
        else h = h + step;
      end
    end
    r.offset = '0;
    r.status = ST_ALLOC_FAIL;
    if (found) begin
      s = hdr_mem[h];
      if (s > 2 * need + SplitSlack) begin
        half = s / 2;
        hdr_mem[h] = 14'(-half);
        if (h + half < int'(POOL_BYTES)) hdr_mem[h + half] = 14'(half + (s % 2));
      end else begin
        hdr_mem[h] = 14'(-s);
      end
      r.offset = OffW'(h + HdrBytes);
      r.status = ST_ALLOC_OK;
    end
    return r;
  endfunction

  function automatic grant_t release_block(input int poff);
    int     h;
    grant_t r;
    r.offset = '0;
    r.status = ST_DOUBLE_FREE;
    if (poff >= HdrBytes && poff - HdrBytes < pool_bytes) begin
      h = poff - HdrBytes;
      if (hdr_mem[h] < 0) begin
        hdr_mem[h] = -hdr_mem[h];
        r.status = ST_FREED;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      for (int i = 0; i < int'(POOL_BYTES); i++) hdr_mem[i] = '0;
      form_pool(CfgW'(PoolResetBytes));
      grant_q.delete();
      err_count = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (grant_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result word offset %0d status %0d",
                   $time, alloc_offset_i, status_i);
        end else begin
          want = grant_q.pop_front();
          if (alloc_offset_i !== want.offset) begin
            err_count++;
            $display("%0t: alloc_offset mismatch expected %0d actual %0d",
                     $time, want.offset, alloc_offset_i);
          end
          if (status_i !== want.status) begin
            err_count++;
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, want.status, status_i);
          end
        end
      end
      if (cfg_we_i) form_pool(cfg_wdata_i);
      if (start_i && !busy_i) begin
        if (kind_i == KIND_ALLOC) grant_q.push_back(first_fit_alloc(int'(req_size_i)));
        else grant_q.push_back(release_block(int'(payload_offset_i)));
      end
      errors_o <= err_count;
      pending_o <= grant_q.size();
    end
  end

endmodule

>>> tb/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CfgW-1:0]  cfg_wdata_i = '0;
  logic             start = 1'b0;
  logic             busy;
  logic [KindW-1:0] kind_i = KIND_ALLOC;
  logic [ReqW-1:0]  req_size_i = '0;
  logic [OffW-1:0]  payload_offset_i = '0;
  logic             done_o;
  logic [OffW-1:0]  alloc_offset_o;
  logic [StatW-1:0] status_o;
  int               errors;
  int               pending;
  int               pool_now = PoolResetBytes;
  logic [OffW-1:0]  granted_offsets [$];

  first_fit_block_allocator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .req_size_i      (req_size_i),
    .payload_offset_i(payload_offset_i),
    .done_o          (done_o),
    .alloc_offset_o  (alloc_offset_o),
    .status_o        (status_o)
  );

  ffba_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_i         (start),
    .busy_i          (busy),
    .kind_i          (kind_i),
    .req_size_i      (req_size_i),
    .payload_offset_i(payload_offset_i),
    .done_i          (done_o),
    .alloc_offset_i  (alloc_offset_o),
    .status_i        (status_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // the latest 512 offsets handed out; their headers were written when granted
  always @(negedge clk_i) begin
    if (rst_ni && done_o && status_o == ST_ALLOC_OK) begin
      granted_offsets.push_back(alloc_offset_o);
      if (granted_offsets.size() > 512) void'(granted_offsets.pop_front());
    end
  end

  task automatic issue_word(input logic [KindW-1:0] kind, input int size, input int poff);
    start <= 1'b1;
    kind_i <= kind;
    req_size_i <= ReqW'(size);
    payload_offset_i <= OffW'(poff);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pool(input int value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CfgW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_now = (value < int'(MinPoolBytes)) ? int'(MinPoolBytes) :
               (value > int'(PoolBytesDef)) ? int'(PoolBytesDef) : value;
  endtask

  task automatic alloc(input int size);
    issue_word(KIND_ALLOC, size, $urandom_range(0, 4095));
  endtask

  task automatic release_word(input int poff);
    issue_word(KIND_FREE, $urandom_range(0, 8191), poff);
  endtask

  initial begin
    int  pick;
    int  size;
    int  poff;
    bit  allow_idle;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // whole pool after reset
    alloc(0);
    alloc(4096);
    alloc(8191);
    alloc(2040);
    alloc(0);
    release_word(4);
    release_word(4);
    release_word(0);
    release_word(3);
    release_word(2052);
    alloc(1);
    alloc(1016);
    release_word(2);
    // smallest pool
    write_pool(0);
    alloc(8);
    alloc(0);
    release_word(4095);
    release_word(20);
    release_word(4);
    // oversized write, then an odd pool so the split leaves the odd byte
    write_pool(8191);
    write_pool(4095);
    alloc(0);
    alloc(2040);
    release_word(2051);
    release_word(2051);

    for (int phase = 0; phase < 14; phase++) begin
      case (phase % 4)
        0: write_pool(4096);
        1: write_pool($urandom_range(16, 300));
        2: write_pool($urandom_range(0, 8191));
        default: write_pool($urandom_range(1000, 4096));
      endcase
      allow_idle = (phase < 12) && (phase % 3 != 2);
      for (int n = 0; n < 106; n++) begin
        if (allow_idle && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
        pick = $urandom_range(0, 99);
        if (pick < 55 || (pick < 90 && granted_offsets.size() == 0)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: size = $urandom_range(0, pool_now / 16);
            6, 7: size = $urandom_range(0, pool_now / 2);
            8: size = $urandom_range(0, 8191);
            default: size = $urandom_range(pool_now - 12, pool_now);
          endcase
          alloc(size);
        end else if (pick < 90) begin
          release_word(granted_offsets[$urandom_range(0, granted_offsets.size() - 1)]);
        end else begin
          if (pool_now <= 4091 && $urandom_range(0, 1) == 1)
            poff = $urandom_range(pool_now + 4, 4095);
          else
            poff = $urandom_range(0, 3);
          release_word(poff);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(300_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
